>>> hdl/svf_pkg.sv
`default_nettype none

package svf_pkg;

  // Field and port widths
  localparam int STATE_WIDTH_DEF = 24;
  localparam int SAMPLE_W        = 16;
  localparam int CUTOFF_W        = 16;
  localparam int FEEDBACK_W      = 15;
  localparam int MODE_W          = 3;
  localparam int CFG_ADDR_W      = 2;
  localparam int CFG_DATA_W      = 16;

  // Product scaling
  localparam int CUTOFF_SHIFT    = 16;
  localparam int FEEDBACK_SHIFT  = 14;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_CUTOFF   = 2'd0,
    REG_FEEDBACK = 2'd1,
    REG_MODE     = 2'd2
  } reg_idx_e;

  // Output selection
  typedef enum logic [MODE_W-1:0] {
    MODE_LP      = 3'd0,
    MODE_HP      = 3'd1,
    MODE_BP      = 3'd2,
    MODE_LP_HP   = 3'd3,
    MODE_LP_BP   = 3'd4,
    MODE_ALL     = 3'd5,
    MODE_HP_BP   = 3'd6,
    MODE_PASS    = 3'd7
  } mode_e;

  // Multiplier operand select
  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_CUT_BAND,
    MUL_CUT_HIGH,
    MUL_BAND_FB
  } mul_sel_e;

  // State update select
  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_LOW,
    UPD_BAND,
    UPD_HIGH
  } upd_sel_e;

  // One control word
  typedef struct packed {
    mul_sel_e mul;
    upd_sel_e upd;
    logic     emit;   // load output register, holds while it is full and not being read
    logic     last;   // end of program
  } ucode_t;

  localparam int NUM_STEPS = 6;
  localparam int PC_W      = $clog2(NUM_STEPS);

  // Filter program
  localparam ucode_t UCODE [NUM_STEPS] = '{
    '{mul: MUL_CUT_BAND, upd: UPD_NONE, emit: 1'b0, last: 1'b0},
    '{mul: MUL_CUT_HIGH, upd: UPD_LOW,  emit: 1'b0, last: 1'b0},
    '{mul: MUL_NONE,     upd: UPD_BAND, emit: 1'b0, last: 1'b0},
    '{mul: MUL_BAND_FB,  upd: UPD_NONE, emit: 1'b0, last: 1'b0},
    '{mul: MUL_NONE,     upd: UPD_HIGH, emit: 1'b0, last: 1'b0},
    '{mul: MUL_NONE,     upd: UPD_NONE, emit: 1'b1, last: 1'b1}
  };

endpackage

`default_nettype wire

>>> hdl/state_variable_filter_multimode.sv
// An accepted request runs the six-step microprogram that shares one multiplier across the
// three products; its final step loads the output register and sets out_valid_o.
// Input ready is low while a request is in flight; the next one is accepted once it ends.
// A result waiting in the output register stalls only the final step of the next request.
// Reset (rst_ni low, asynchronous): states zero, cutoff and feedback zero, mode passthrough,
// sequencer idle, output register empty.
`default_nettype none

module state_variable_filter_multimode import svf_pkg::*; #(
  parameter int STATE_WIDTH = STATE_WIDTH_DEF
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire  signed [SAMPLE_W-1:0]  sample_in_i,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output logic signed [SAMPLE_W-1:0]  sample_out_o,
  input  wire                         cfg_we_i,
  input  wire         [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire         [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int PW = STATE_WIDTH + CUTOFF_W + 1;  // product width
  localparam int EW = PW + 2;                      // state update width
  localparam int OW = STATE_WIDTH + 2;             // output sum width

  localparam logic signed [STATE_WIDTH-1:0] ST_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
  localparam logic signed [STATE_WIDTH-1:0] ST_MIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0]    OUT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0]    OUT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  function automatic logic signed [STATE_WIDTH-1:0] sat_state(input logic signed [EW-1:0] v);
    if (v > ST_MAX) return ST_MAX;
    if (v < ST_MIN) return ST_MIN;
    return v[STATE_WIDTH-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_out(input logic signed [OW-1:0] v);
    if (v > OUT_MAX) return OUT_MAX;
    if (v < OUT_MIN) return OUT_MIN;
    return v[SAMPLE_W-1:0];
  endfunction

  // Configuration registers
  logic [CUTOFF_W-1:0]   cutoff_q;
  logic [FEEDBACK_W-1:0] feedback_q;
  mode_e                 mode_q;

  // Filter state and datapath registers
  logic signed [STATE_WIDTH-1:0] low_q, band_q, high_q;
  logic signed [SAMPLE_W-1:0]    x_q;
  logic signed [PW-1:0]          prod_q;
  logic signed [SAMPLE_W-1:0]    out_q;
  logic                          out_valid_q, out_valid_d;

  // Sequencer
  logic            busy_q, busy_d;
  logic [PC_W-1:0] pc_q, pc_d;
  ucode_t          uc;
  logic            in_accept, can_emit, do_emit, stall;

  assign in_ready_o   = !busy_q;
  assign in_accept    = in_valid_i && in_ready_o;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

  // Current control word, no-op while idle
  always_comb begin
    uc = UCODE[pc_q];
    if (!busy_q) begin
      uc = '{mul: MUL_NONE, upd: UPD_NONE, emit: 1'b0, last: 1'b0};
    end
  end

  assign can_emit = !out_valid_q || out_ready_i;
  assign do_emit  = uc.emit && can_emit;
  assign stall    = uc.emit && !can_emit;

  // Step counter and conditional hold on the emit step
  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (in_accept) begin
      busy_d = 1'b1;
      pc_d   = '0;
    end else if (busy_q && !stall) begin
      if (uc.last) begin
        busy_d = 1'b0;
        pc_d   = '0;
      end else begin
        pc_d = pc_q + 1'b1;
      end
    end
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (do_emit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Config writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q   <= '0;
      feedback_q <= '0;
      mode_q     <= MODE_PASS;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_addr_i))
        REG_CUTOFF:   cutoff_q   <= cfg_wdata_i[CUTOFF_W-1:0];
        REG_FEEDBACK: feedback_q <= cfg_wdata_i[FEEDBACK_W-1:0];
        REG_MODE:     mode_q     <= mode_e'(cfg_wdata_i[MODE_W-1:0]);
        default:      ;
      endcase
    end
  end

  // Shared multiplier operands
  logic signed [STATE_WIDTH-1:0] mul_a;
  logic signed [CUTOFF_W:0]      mul_b;
  logic signed [PW-1:0]          prod_full;

  always_comb begin
    mul_a = band_q;
    mul_b = $signed({1'b0, cutoff_q});
    case (uc.mul)
      MUL_CUT_BAND: begin
        mul_a = band_q;
        mul_b = $signed({1'b0, cutoff_q});
      end
      MUL_CUT_HIGH: begin
        mul_a = high_q;
        mul_b = $signed({1'b0, cutoff_q});
      end
      MUL_BAND_FB: begin
        mul_a = band_q;
        mul_b = $signed({{(CUTOFF_W + 1 - FEEDBACK_W){1'b0}}, feedback_q});
      end
      default: ;
    endcase
  end

  assign prod_full = PW'(mul_a) * PW'(mul_b);

  always_ff @(posedge clk_i) begin
    if (uc.mul != MUL_NONE) prod_q <= prod_full;
    if (in_accept) x_q <= sample_in_i;
  end

  // State updates, floor scaling by arithmetic shift
  logic signed [PW-1:0] sh_cut, sh_fb;
  logic signed [EW-1:0] low_sum, band_sum, high_sum;

  assign sh_cut   = prod_q >>> CUTOFF_SHIFT;
  assign sh_fb    = prod_q >>> FEEDBACK_SHIFT;
  assign low_sum  = EW'(low_q) - EW'(sh_cut);
  assign band_sum = EW'(band_q) - EW'(sh_cut);
  assign high_sum = EW'(sh_fb) - EW'(low_q) - EW'(x_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      band_q <= '0;
      high_q <= '0;
    end else begin
      case (uc.upd)
        UPD_LOW:  low_q  <= sat_state(low_sum);
        UPD_BAND: band_q <= sat_state(band_sum);
        UPD_HIGH: high_q <= sat_state(high_sum);
        default:  ;
      endcase
    end
  end

  // Output mix
  logic signed [OW-1:0] mix;

  always_comb begin
    case (mode_q)
      MODE_LP:    mix = OW'(low_q);
      MODE_HP:    mix = OW'(high_q);
      MODE_BP:    mix = OW'(band_q);
      MODE_LP_HP: mix = OW'(low_q) + OW'(high_q);
      MODE_LP_BP: mix = OW'(low_q) + OW'(band_q);
      MODE_ALL:   mix = OW'(low_q) + OW'(band_q) + OW'(high_q);
      MODE_HP_BP: mix = OW'(band_q) + OW'(high_q);
      default:    mix = OW'(x_q);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_emit) out_q <= sat_out(mix);
  end

endmodule

`default_nettype wire

>>> hdl/svf_checker.sv
`default_nettype none

module svf_props import svf_pkg::*; (
  input wire                        clk_i,
  input wire                        rst_ni,
  input wire                        in_valid_i,
  input wire                        in_ready_o,
  input wire                        out_valid_o,
  input wire                        out_ready_i,
  input wire signed [SAMPLE_W-1:0]  sample_out_o
);

  // One request at a time: accepting closes the input
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input still ready after accept");

  // A result only appears while a request is in flight
  a_result_from_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without request in flight");

  // Fixed latency when the output register is free
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |-> ##7 out_valid_o)
    else $error("result late");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_out_o))
    else $error("stalled result changed");

endmodule

bind state_variable_filter_multimode svf_props u_svf_checker (.*);

`default_nettype wire
